// File: hw/rtl/iaca_pkg.sv
// shared constants, types and slot routing for the interleaved converter channel averager
package iaca_pkg;

	localparam int SLOTS_PER_FRAME = 24;
	localparam int OUT_CHANNELS    = 16;
	localparam int MAX_FRAMES_DEF  = 64;
	localparam int SAMPLE_BITS     = 12;
	localparam int CFG_W           = 7;
	localparam int POS_W           = $clog2(SLOTS_PER_FRAME);
	localparam int CH_W            = $clog2(OUT_CHANNELS);

	localparam logic [CFG_W-1:0] FRAMES_RESET = 7'd50;

	typedef struct packed {
		logic            used;
		logic [CH_W-1:0] ch;
	} slot_route_t;

	// middle converter slots (1 mod 3) are dropped
	function automatic slot_route_t slot_route(input logic [POS_W-1:0] pos);
		slot_route_t r;
		r.used = 1'b1;
		r.ch   = '0;
		unique case (pos)
			5'd0:  r.ch = 4'd0;
			5'd3:  r.ch = 4'd1;
			5'd6:  r.ch = 4'd2;
			5'd9:  r.ch = 4'd3;
			5'd2:  r.ch = 4'd4;
			5'd5:  r.ch = 4'd5;
			5'd8:  r.ch = 4'd6;
			5'd11: r.ch = 4'd7;
			5'd14: r.ch = 4'd8;
			5'd17: r.ch = 4'd9;
			5'd12: r.ch = 4'd10;
			5'd15: r.ch = 4'd11;
			5'd18: r.ch = 4'd12;
			5'd21: r.ch = 4'd13;
			5'd20: r.ch = 4'd14;
			5'd23: r.ch = 4'd15;
			default: r.used = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/interleaved_adc_channel_averager_core.sv
// interleaved converter channel averager: per-channel accumulate, shared serial divider on emit
//
//  channel  | signals                                   | request
//  ---------+-------------------------------------------+-------------------------------
//  input    | in_valid, in_stall, sample                | one converter slot sample
//  output   | out_valid, out_stall, channel, average,   | one channel average
//           | last                                      |
//  config   | frames_per_block_wr, frames_per_block     | frames per block, no read-back
//
// samples are taken one per cycle while accumulating.
// on the last slot of a block the 16 channels are divided one after another by a
// single restoring divider: per channel a load state, then one step per quotient bit
// (SUM_W bits, 18 at defaults), then an output state holding the result.
// in_stall stays high throughout the emit; out_stall only lengthens the result hold.
// reset clears all sums and the slot, frame and channel counters at once; no clearing pass is needed.
module interleaved_adc_channel_averager_core #(
	parameter int MAX_FRAMES = iaca_pkg::MAX_FRAMES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             frames_per_block_wr,
	input  logic [iaca_pkg::CFG_W-1:0]       frames_per_block,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [iaca_pkg::SAMPLE_BITS-1:0] sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [iaca_pkg::CH_W-1:0]        channel,
	output logic [iaca_pkg::SAMPLE_BITS-1:0] average,
	output logic                             last
);
	import iaca_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_FRAMES);
	localparam int DIV_W  = $clog2(MAX_FRAMES + 1);
	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [SUM_W-1:0] SAT = SUM_W'((1 << SAMPLE_BITS) - 1);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       cfg_frames_q;
	logic [POS_W-1:0]       pos_q;
	logic [DIV_W-1:0]       frame_q;
	logic [CH_W-1:0]        ch_q;
	logic [SUM_W-1:0]       sums_q [OUT_CHANNELS];
	logic [DIV_W-1:0]       div_q;
	logic [DIV_W-1:0]       rem_q;
	logic [SUM_W-1:0]       quo_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS-1:0] avg_q;

	slot_route_t            route;
	logic [CH_W-1:0]        rd_idx;
	logic [SUM_W-1:0]       rd_sum;
	logic [SUM_W-1:0]       sum_add;
	logic [DIV_W-1:0]       eff_frames;
	logic [DIV_W:0]         trial;
	logic                   ge;
	logic [DIV_W-1:0]       rem_nx;
	logic [SUM_W-1:0]       quo_nx;

	// zero acts as one, above the maximum clamps to it
	always_comb begin
		if (cfg_frames_q == '0) begin
			eff_frames = DIV_W'(1);
		end else if (32'(cfg_frames_q) > 32'(MAX_FRAMES)) begin
			eff_frames = DIV_W'(MAX_FRAMES);
		end else begin
			eff_frames = DIV_W'(cfg_frames_q);
		end
	end

	// one read port on the sums, shared by accumulate and divider load
	always_comb begin
		route   = slot_route(pos_q);
		rd_idx  = (state_q == ST_ACC) ? route.ch : ch_q;
		rd_sum  = sums_q[rd_idx];
		sum_add = rd_sum + SUM_W'(sample);
	end

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial  = {rem_q, quo_q[SUM_W-1]};
		ge     = (trial >= {1'b0, div_q});
		rem_nx = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
		quo_nx = {quo_q[SUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_ACC;
			cfg_frames_q <= FRAMES_RESET;
			pos_q        <= '0;
			frame_q      <= '0;
			ch_q         <= '0;
			for (int i = 0; i < OUT_CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (frames_per_block_wr) begin
				cfg_frames_q <= frames_per_block;
			end
			unique case (state_q)
				ST_ACC: begin
					if (in_valid) begin
						if (route.used) begin
							sums_q[rd_idx] <= sum_add;
						end
						if (pos_q == POS_W'(SLOTS_PER_FRAME - 1)) begin
							pos_q <= '0;
							if ((DIV_W + 1)'(frame_q) + 1'b1 < (DIV_W + 1)'(eff_frames)) begin
								frame_q <= frame_q + 1'b1;
							end else begin
								// divisor is whatever was in force when the block closed
								frame_q <= '0;
								div_q   <= eff_frames;
								ch_q    <= '0;
								state_q <= ST_LOAD;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_LOAD: begin
					quo_q          <= rd_sum;
					rem_q          <= '0;
					step_q         <= '0;
					sums_q[rd_idx] <= '0;
					state_q        <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= quo_nx;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						// saturate when a mid-block change pushed the quotient past sample range
						avg_q   <= (quo_nx > SAT) ? SAT[SAMPLE_BITS-1:0]
						                          : quo_nx[SAMPLE_BITS-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (last) begin
							state_q <= ST_ACC;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_ACC);
	assign out_valid = (state_q == ST_OUT);
	assign channel   = ch_q;
	assign average   = avg_q;
	assign last      = (ch_q == CH_W'(OUT_CHANNELS - 1));

endmodule

// File: hw/rtl/iaca_checker.sv
// port-level checks for the interleaved converter channel averager, bound to the top level
module iaca_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [iaca_pkg::CH_W-1:0]        channel,
	input logic [iaca_pkg::SAMPLE_BITS-1:0] average,
	input logic                             last
);
	import iaca_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel) && $stable(average)
			&& $stable(last))
		else $error("stalled result changed");

	// no sample is taken while results are pending
	a_no_input_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during emit");

	// last marks the final channel only
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (channel == CH_W'(OUT_CHANNELS - 1))))
		else $error("last flag does not match channel");

	// after a non-final result the emit carries on with input still closed
	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> in_stall && !out_valid)
		else $error("emit ended early");

	// emit always starts at channel zero
	a_first_channel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> channel == '0)
		else $error("emit did not start at channel zero");

endmodule

bind interleaved_adc_channel_averager_core iaca_checker u_iaca_checker (.*);
